// ===== hdl/rbb_pkg.sv =====
package rbb_pkg;

    // Fixed field widths
    localparam int CAP_W  = 9;
    localparam int SUM_W  = 10;
    localparam int DATA_W = 8;

    // Smallest capacity that keeps one slot free and still stores a byte
    localparam logic [CAP_W-1:0] MIN_CAP = 9'd2;

    // Operation codes carried on the input tuser
    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_PEEK  = 2'd1,
        FUNC_DROP  = 2'd2,
        FUNC_ADV   = 2'd3
    } t_func;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic latch;
        logic exec;
        logic fin;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_adv;
        logic mod_done;
        logic out_free;
    } t_sts;

endpackage

// ===== hdl/ring_byte_buffer_with_peek_and_drop.sv =====
// Circular byte receive buffer with peek and drop. Each input beat carries one
// operation on tuser (write, peek, drop, advance read pointer) with the byte and
// the amount on tdata; each operation returns one result beat with the accepted
// flag on tuser and the peeked byte, fill level and free space on tdata. One
// slot always stays empty, so the usable depth is the capacity minus one.
// Writing the capacity register empties the buffer. Operations run one at a
// time: write, peek and drop step through accept, execute and result;
// advance waits between execute and result, as the wrapped head comes from
// a remainder unit that resolves one bit per cycle over 10 bits. A result
// waiting in the output register holds the next acceptance.
module ring_byte_buffer_with_peek_and_drop #(
    parameter int MAX_SLOTS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // data_byte [7:0], amount [16:8], zero [23:17]
    input  logic [1:0]  s_axis_tuser,  // func [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // peeked_byte [7:0], fill_level [15:8], free_space [23:16]
    output logic [0:0]  m_axis_tuser   // accepted [0]
);
    import rbb_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequence the operations
    rbb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Store, pointers and result register
    rbb_dp #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_data     (s_axis_tdata),
        .i_in_func     (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Take no second beat while the first is still in work
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an operation is in work");

    // The remainder unit only finishes while the input is closed
    a_mod_busy_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.mod_done |-> !s_axis_tready)
        else $error("remainder finished with input open");

    // A finished operation lands in the output register
    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.fin && w_sts.out_free |=> m_axis_tvalid)
        else $error("result not presented after finish");

    // A refused operation never reports a peeked byte
    a_refused_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("refused operation carries a byte");

endmodule

// ===== hdl/rbb_mod.sv =====
module rbb_mod (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rbb_pkg::SUM_W-1:0]  i_dividend,
    input  logic [rbb_pkg::CAP_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [rbb_pkg::CAP_W-1:0]  o_rem
);
    import rbb_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_cnt;
    logic [SUM_W-1:0]    r_num;
    logic [CAP_W-1:0]    r_rem;
    logic [CAP_W:0]      n_trial;
    logic [CAP_W-1:0]    n_rem;

    // Bring down the next dividend bit and subtract the divisor if it fits
    always_comb begin
        n_trial = {r_rem, r_num[SUM_W-1]};
        if (n_trial >= {1'b0, i_divisor}) begin
            n_rem = CAP_W'(n_trial - {1'b0, i_divisor});
        end else begin
            n_rem = n_trial[CAP_W-1:0];
        end
    end

    // Sequence one remainder bit per cycle, most significant first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Shift the dividend out and hold the partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= LAST_STEP;
            r_num <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_num <= {r_num[SUM_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== hdl/rbb_dp.sv =====
module rbb_dp #(
    parameter int MAX_SLOTS = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rbb_pkg::t_cmd              i_cmd,
    output rbb_pkg::t_sts              o_sts,
    input  logic                       i_cfg_we,
    input  logic [rbb_pkg::CAP_W-1:0]  i_cfg_wdata,
    input  logic [23:0]                i_in_data,   // data_byte, amount, zero pad
    input  logic [1:0]                 i_in_func,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [23:0]                m_axis_tdata, // peeked_byte, fill_level, free_space
    output logic [0:0]                 m_axis_tuser  // accepted
);
    import rbb_pkg::*;

    localparam int DEPTH = (MAX_SLOTS < 256) ? MAX_SLOTS : 256;
    localparam int PW    = $clog2(DEPTH);
    localparam logic [CAP_W-1:0] MAX_CAP = CAP_W'(DEPTH);

    logic [DATA_W-1:0] r_mem [DEPTH];

    logic [CAP_W-1:0]  r_cap;
    logic [PW-1:0]     r_head;
    logic [PW-1:0]     r_tail;
    t_func             r_func;
    logic [DATA_W-1:0] r_data;
    logic [CAP_W-1:0]  r_amt;
    logic              r_ok;
    logic [DATA_W-1:0] r_rd_data;
    logic              r_out_valid;
    logic              r_out_ok;
    logic [DATA_W-1:0] r_out_peek;
    logic [DATA_W-1:0] r_out_fill;
    logic [DATA_W-1:0] r_out_free;

    logic [CAP_W-1:0]  n_cap;
    logic [CAP_W-1:0]  w_head9;
    logic [CAP_W-1:0]  w_tail9;
    logic [CAP_W-1:0]  w_fill;
    logic [CAP_W-1:0]  w_free;
    logic [SUM_W-1:0]  w_sum;
    logic [SUM_W-1:0]  w_wrap;
    logic [PW-1:0]     w_idx;
    logic [PW-1:0]     w_tail_nx;
    logic              w_wr_ok;
    logic              w_pk_ok;
    logic              w_drop_all;
    logic              w_ok;
    logic              w_load;
    logic              w_mod_start;
    logic              w_mod_done;
    logic [CAP_W-1:0]  w_mod_rem;

    // Saturate the written capacity into the supported range
    always_comb begin
        priority if (i_cfg_wdata > MAX_CAP) begin
            n_cap = MAX_CAP;
        end else if (i_cfg_wdata < MIN_CAP) begin
            n_cap = MIN_CAP;
        end else begin
            n_cap = i_cfg_wdata;
        end
    end

    // Fill level and free space from the pointers
    always_comb begin
        w_head9 = CAP_W'(r_head);
        w_tail9 = CAP_W'(r_tail);
        if (w_tail9 >= w_head9) begin
            w_fill = w_tail9 - w_head9;
        end else begin
            w_fill = r_cap - w_head9 + w_tail9;
        end
        w_free = r_cap - CAP_W'(1) - w_fill;
    end

    // Offset from the head, wrapped once (enough when the offset is below the fill level)
    always_comb begin
        w_sum = SUM_W'(r_amt) + SUM_W'(w_head9);
        if (w_sum >= SUM_W'(r_cap)) begin
            w_wrap = w_sum - SUM_W'(r_cap);
        end else begin
            w_wrap = w_sum;
        end
        w_idx = w_wrap[PW-1:0];
    end

    // Tail advance with wrap
    assign w_tail_nx = ((w_tail9 + CAP_W'(1)) == r_cap) ? '0 : r_tail + 1'b1;

    // Decide acceptance for the latched operation
    always_comb begin
        w_wr_ok    = (r_amt != '0) && (r_amt <= w_free);
        w_pk_ok    = (r_amt < w_fill);
        w_drop_all = (r_amt >= w_fill);
        unique case (r_func)
            FUNC_WRITE: w_ok = w_wr_ok;
            FUNC_PEEK:  w_ok = w_pk_ok;
            FUNC_DROP:  w_ok = 1'b1;
            FUNC_ADV:   w_ok = 1'b1;
        endcase
    end

    assign w_load      = i_cmd.fin && o_sts.out_free;
    assign w_mod_start = i_cmd.exec && (r_func == FUNC_ADV);

    // Remainder unit for the unchecked head advance
    rbb_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (w_sum),
        .i_divisor  (r_cap),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    // Byte store: append on write, registered read on peek
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && (r_func == FUNC_WRITE) && w_wr_ok) begin
            r_mem[r_tail] <= r_data;
        end
        if (i_cmd.exec && (r_func == FUNC_PEEK)) begin
            r_rd_data <= r_mem[w_idx];
        end
    end

    // Capacity and pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= MAX_CAP;
            r_head <= '0;
            r_tail <= '0;
        end else if (i_cfg_we) begin
            r_cap  <= n_cap;
            r_head <= '0;
            r_tail <= '0;
        end else if (i_cmd.exec) begin
            unique case (r_func)
                FUNC_WRITE: begin
                    if (w_wr_ok) begin
                        r_tail <= w_tail_nx;
                    end
                end
                FUNC_DROP: begin
                    if (w_drop_all) begin
                        r_head <= '0;
                        r_tail <= '0;
                    end else begin
                        r_head <= w_idx;
                    end
                end
                FUNC_PEEK: ;
                FUNC_ADV:  ;
            endcase
        end else if (w_mod_done) begin
            r_head <= w_mod_rem[PW-1:0];
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Latch the beat, the verdict and the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func <= t_func'(i_in_func);
            r_data <= i_in_data[7:0];
            r_amt  <= i_in_data[16:8];
        end
        if (i_cmd.exec) begin
            r_ok <= w_ok;
        end
        if (w_load) begin
            r_out_ok   <= r_ok;
            r_out_peek <= ((r_func == FUNC_PEEK) && r_ok) ? r_rd_data : '0;
            r_out_fill <= w_fill[DATA_W-1:0];
            r_out_free <= w_free[DATA_W-1:0];
        end
    end

    assign o_sts.is_adv   = (r_func == FUNC_ADV);
    assign o_sts.mod_done = w_mod_done;
    assign o_sts.out_free = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_free, r_out_fill, r_out_peek};
    assign m_axis_tuser  = r_out_ok;

endmodule

// ===== hdl/rbb_ctrl.sv =====
module rbb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rbb_pkg::t_sts  i_sts,
    output rbb_pkg::t_cmd  o_cmd
);
    import rbb_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MOD,
        ST_FIN
    } t_state;

    t_state r_state;
    logic   r_ready;

    // Step through one operation at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ready <= 1'b1;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid && r_ready) begin
                        r_state <= ST_EXEC;
                        r_ready <= 1'b0;
                    end
                end
                ST_EXEC: begin
                    r_state <= i_sts.is_adv ? ST_MOD : ST_FIN;
                end
                ST_MOD: begin
                    if (i_sts.mod_done) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (i_sts.out_free) begin
                        r_state <= ST_IDLE;
                        r_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    assign o_in_ready  = r_ready;
    assign o_cmd.latch = i_in_valid && r_ready;
    assign o_cmd.exec  = (r_state == ST_EXEC);
    assign o_cmd.fin   = (r_state == ST_FIN);

endmodule
